FILE: hw/rtl/irpd_pkg.sv
// Shared constants for the IR pulse-distance transmitter.
package irpd_pkg;

  localparam int FRAME_BITS_DEFAULT = 32;

  localparam int FRAME_W   = 32;
  localparam int HALF_W    = 8;
  localparam int CYCLES_W  = 10;
  localparam int TICKS_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CARRIER_HALF = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_MARK     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_SPACE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_MARK     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SPACE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE    = 3'd5;

  localparam logic [HALF_W-1:0]   RST_CARRIER_HALF = 8'd7;
  localparam logic [CYCLES_W-1:0] RST_HDR_MARK     = 10'd71;
  localparam logic [TICKS_W-1:0]  RST_HDR_SPACE    = 16'd1000;
  localparam logic [CYCLES_W-1:0] RST_BIT_MARK     = 10'd18;
  localparam logic [TICKS_W-1:0]  RST_ZERO_SPACE   = 16'd350;
  localparam logic [TICKS_W-1:0]  RST_ONE_SPACE    = 16'd700;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

endpackage

FILE: hw/rtl/ir_pulse_distance_transmitter_unit.sv
// Top level of the IR pulse-distance transmitter: frame sequencer and output register.
//
//  channel | direction | handshake             | payload
//  in      | in        | in_valid / in_ready   | kind, frame_word
//  out     | out       | out_valid / out_ready | ir_out, busy_res, frame_done, start_ignored
//  cfg     | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One item per cycle: each transfer on in updates the sequencer and loads the
// result register in the same cycle. in_ready is high while the result register
// is empty or being taken, so a stalled out channel holds in. Synchronous reset
// returns the sequencer to idle and the timing registers to their defaults;
// cfg_ready is always high.
module ir_pulse_distance_transmitter_unit #(
  parameter int FRAME_BITS = irpd_pkg::FRAME_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           kind,
  input  logic [irpd_pkg::FRAME_W-1:0]   frame_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           ir_out,
  output logic                           busy_res,
  output logic                           frame_done,
  output logic                           start_ignored,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [irpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [irpd_pkg::CFG_DAT_W-1:0] cfg_data
);

  localparam int BL_W = $clog2(FRAME_BITS + 1);

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_HDR_MARK  = 3'd1,
    PH_HDR_SPACE = 3'd2,
    PH_BIT_MARK  = 3'd3,
    PH_BIT_SPACE = 3'd4
  } phase_t;

  logic [irpd_pkg::HALF_W-1:0]   carrier_half_ticks;
  logic [irpd_pkg::CYCLES_W-1:0] header_mark_cycles;
  logic [irpd_pkg::TICKS_W-1:0]  header_space_ticks;
  logic [irpd_pkg::CYCLES_W-1:0] bit_mark_cycles;
  logic [irpd_pkg::TICKS_W-1:0]  zero_space_ticks;
  logic [irpd_pkg::TICKS_W-1:0]  one_space_ticks;

  phase_t                        phase, phase_next;
  logic [irpd_pkg::FRAME_W-1:0]  shift_frame, shift_frame_next;
  logic [BL_W-1:0]               bits_left, bits_left_next, bits_dec;
  logic [irpd_pkg::TICKS_W-1:0]  tick_count, tick_count_next, tick_inc;
  logic [irpd_pkg::CYCLES_W-1:0] cycle_count, cycle_count_next, cycle_inc;
  logic                          carrier_level, carrier_level_next;

  logic [irpd_pkg::CYCLES_W-1:0] mark_cycles;
  logic [irpd_pkg::TICKS_W-1:0]  space_ticks;
  logic [irpd_pkg::TICKS_W-1:0]  mark_tick_next;
  logic [irpd_pkg::CYCLES_W-1:0] mark_cycle_next;
  logic                          mark_level_next, mark_end;
  logic [irpd_pkg::TICKS_W-1:0]  space_tick_next;
  logic                          space_end;

  logic level, done, ignored;
  logic in_xfer;

  assign in_ready  = !out_valid || out_ready;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign tick_inc  = tick_count + 1'b1;
  assign cycle_inc = cycle_count + 1'b1;
  assign bits_dec  = (bits_left != '0) ? bits_left - 1'b1 : bits_left;

  assign mark_cycles = (phase == PH_HDR_MARK) ? header_mark_cycles : bit_mark_cycles;
  assign space_ticks = (phase == PH_HDR_SPACE) ? header_space_ticks :
                       (shift_frame[0] ? one_space_ticks : zero_space_ticks);

  // advance one carrier tick
  always_comb begin
    mark_tick_next  = tick_inc;
    mark_cycle_next = cycle_count;
    mark_level_next = carrier_level;
    mark_end        = 1'b0;
    if (tick_inc >= {{(irpd_pkg::TICKS_W - irpd_pkg::HALF_W){1'b0}}, carrier_half_ticks}) begin
      mark_tick_next = '0;
      if (carrier_level) begin
        mark_level_next = 1'b0;
      end else if (cycle_inc >= mark_cycles) begin
        mark_cycle_next = '0;
        mark_level_next = 1'b0;
        mark_end        = 1'b1;
      end else begin
        mark_cycle_next = cycle_inc;
        mark_level_next = 1'b1;
      end
    end
  end

  // advance one space tick
  always_comb begin
    space_end       = tick_inc >= space_ticks;
    space_tick_next = space_end ? '0 : tick_inc;
  end

  always_comb begin
    phase_next         = phase;
    shift_frame_next   = shift_frame;
    bits_left_next     = bits_left;
    tick_count_next    = tick_count;
    cycle_count_next   = cycle_count;
    carrier_level_next = carrier_level;
    level              = 1'b0;
    done               = 1'b0;
    ignored            = 1'b0;
    if (kind == irpd_pkg::KIND_START) begin
      if (phase != PH_IDLE) begin
        ignored = 1'b1;
        level   = ((phase == PH_HDR_MARK) || (phase == PH_BIT_MARK)) && carrier_level;
      end else begin
        shift_frame_next   = frame_word;
        bits_left_next     = BL_W'(FRAME_BITS);
        phase_next         = PH_HDR_MARK;
        tick_count_next    = '0;
        cycle_count_next   = '0;
        carrier_level_next = 1'b1;
        level              = 1'b1;
      end
    end else begin
      case (phase)
        PH_IDLE: begin
          phase_next = PH_IDLE;
        end
        PH_HDR_MARK, PH_BIT_MARK: begin
          level              = carrier_level;
          tick_count_next    = mark_tick_next;
          cycle_count_next   = mark_cycle_next;
          carrier_level_next = mark_level_next;
          if (mark_end) begin
            phase_next = (phase == PH_HDR_MARK) ? PH_HDR_SPACE : PH_BIT_SPACE;
          end
        end
        PH_HDR_SPACE: begin
          tick_count_next = space_tick_next;
          if (space_end) begin
            phase_next         = PH_BIT_MARK;
            carrier_level_next = 1'b1;
          end
        end
        PH_BIT_SPACE: begin
          tick_count_next = space_tick_next;
          if (space_end) begin
            shift_frame_next = shift_frame >> 1;
            bits_left_next   = bits_dec;
            if (bits_dec == '0) begin
              phase_next = PH_IDLE;
              done       = 1'b1;
            end else begin
              phase_next         = PH_BIT_MARK;
              carrier_level_next = 1'b1;
            end
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      shift_frame   <= '0;
      bits_left     <= '0;
      tick_count    <= '0;
      cycle_count   <= '0;
      carrier_level <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (in_xfer) begin
        phase         <= phase_next;
        shift_frame   <= shift_frame_next;
        bits_left     <= bits_left_next;
        tick_count    <= tick_count_next;
        cycle_count   <= cycle_count_next;
        carrier_level <= carrier_level_next;
        out_valid     <= 1'b1;
        ir_out        <= level;
        busy_res      <= (phase_next != PH_IDLE);
        frame_done    <= done;
        start_ignored <= ignored;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carrier_half_ticks <= irpd_pkg::RST_CARRIER_HALF;
      header_mark_cycles <= irpd_pkg::RST_HDR_MARK;
      header_space_ticks <= irpd_pkg::RST_HDR_SPACE;
      bit_mark_cycles    <= irpd_pkg::RST_BIT_MARK;
      zero_space_ticks   <= irpd_pkg::RST_ZERO_SPACE;
      one_space_ticks    <= irpd_pkg::RST_ONE_SPACE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        irpd_pkg::CFG_CARRIER_HALF: carrier_half_ticks <= cfg_data[irpd_pkg::HALF_W-1:0];
        irpd_pkg::CFG_HDR_MARK:     header_mark_cycles <= cfg_data[irpd_pkg::CYCLES_W-1:0];
        irpd_pkg::CFG_HDR_SPACE:    header_space_ticks <= cfg_data;
        irpd_pkg::CFG_BIT_MARK:     bit_mark_cycles    <= cfg_data[irpd_pkg::CYCLES_W-1:0];
        irpd_pkg::CFG_ZERO_SPACE:   zero_space_ticks   <= cfg_data;
        irpd_pkg::CFG_ONE_SPACE:    one_space_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> !busy_res)
    else $error("frame_done with busy_res set");

  a_ignored_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && start_ignored |-> busy_res)
    else $error("ignored start while idle");

  a_pin_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && ir_out |-> busy_res)
    else $error("pin high outside a frame");

  a_start_load: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (kind == irpd_pkg::KIND_START) && (phase == PH_IDLE)
      |=> (phase == PH_HDR_MARK) && carrier_level && (bits_left == BL_W'(FRAME_BITS)))
    else $error("start did not load the header mark");

  a_bits_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_BIT_MARK) || (phase == PH_BIT_SPACE) |-> (bits_left != '0))
    else $error("bit phase with no bits left");

endmodule

FILE: sim/tb_ir_pulse_distance_transmitter_unit.sv
// Testbench for the IR pulse-distance transmitter: random traffic against a frame predictor.
module tb_ir_pulse_distance_transmitter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    TX_IDLE, TX_HDR_MARK, TX_HDR_SPACE, TX_BIT_MARK, TX_BIT_SPACE
  } tx_phase_t;

  typedef struct packed {
    logic ir;
    logic busy;
    logic done;
    logic ignored;
  } pin_result_t;

  localparam int MAX_REPORTS = 10;
  localparam int LONG_HOLD   = 80;
  localparam logic [irpd_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [irpd_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  class IrFrameScoreboard;
    logic [irpd_pkg::HALF_W-1:0]   carrier_half;
    logic [irpd_pkg::CYCLES_W-1:0] hdr_cycles;
    logic [irpd_pkg::TICKS_W-1:0]  hdr_space;
    logic [irpd_pkg::CYCLES_W-1:0] bit_cycles;
    logic [irpd_pkg::TICKS_W-1:0]  zero_space;
    logic [irpd_pkg::TICKS_W-1:0]  one_space;
    tx_phase_t                     phase;
    logic [irpd_pkg::FRAME_W-1:0]  shift_word;
    logic [5:0]                    bits_left;
    logic [irpd_pkg::TICKS_W-1:0]  ticks;
    logic [irpd_pkg::CYCLES_W-1:0] cycles;
    logic                          carrier;
    pin_result_t                   expected_q[$];
    int                            mismatches;

    function new();
      carrier_half = irpd_pkg::RST_CARRIER_HALF;
      hdr_cycles   = irpd_pkg::RST_HDR_MARK;
      hdr_space    = irpd_pkg::RST_HDR_SPACE;
      bit_cycles   = irpd_pkg::RST_BIT_MARK;
      zero_space   = irpd_pkg::RST_ZERO_SPACE;
      one_space    = irpd_pkg::RST_ONE_SPACE;
      phase        = TX_IDLE;
      shift_word   = '0;
      bits_left    = '0;
      ticks        = '0;
      cycles       = '0;
      carrier      = 1'b0;
      mismatches   = 0;
    endfunction

    function void write_reg(logic [irpd_pkg::CFG_IDX_W-1:0] idx,
                            logic [irpd_pkg::CFG_DAT_W-1:0] data);
      case (idx)
        irpd_pkg::CFG_CARRIER_HALF: carrier_half = data[irpd_pkg::HALF_W-1:0];
        irpd_pkg::CFG_HDR_MARK:     hdr_cycles   = data[irpd_pkg::CYCLES_W-1:0];
        irpd_pkg::CFG_HDR_SPACE:    hdr_space    = data[irpd_pkg::TICKS_W-1:0];
        irpd_pkg::CFG_BIT_MARK:     bit_cycles   = data[irpd_pkg::CYCLES_W-1:0];
        irpd_pkg::CFG_ZERO_SPACE:   zero_space   = data[irpd_pkg::TICKS_W-1:0];
        irpd_pkg::CFG_ONE_SPACE:    one_space    = data[irpd_pkg::TICKS_W-1:0];
        default: ;
      endcase
    endfunction

    function bit mark_step(logic [irpd_pkg::CYCLES_W-1:0] limit);
      ticks = ticks + 1'b1;
      if (ticks >= carrier_half) begin
        ticks = '0;
        if (carrier) begin
          carrier = 1'b0;
        end else begin
          carrier = 1'b1;
          cycles  = cycles + 1'b1;
          if (cycles >= limit) begin
            cycles  = '0;
            carrier = 1'b0;
            return 1'b1;
          end
        end
      end
      return 1'b0;
    endfunction

    function bit space_step(logic [irpd_pkg::TICKS_W-1:0] limit);
      ticks = ticks + 1'b1;
      if (ticks >= limit) begin
        ticks = '0;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_input(logic k, logic [irpd_pkg::FRAME_W-1:0] word);
      pin_result_t r;
      r = '0;
      if (k == irpd_pkg::KIND_START) begin
        if (phase != TX_IDLE) begin
          r.ignored = 1'b1;
        end else begin
          shift_word = word;
          bits_left  = 6'(irpd_pkg::FRAME_BITS_DEFAULT);
          phase      = TX_HDR_MARK;
          ticks      = '0;
          cycles     = '0;
          carrier    = 1'b1;
        end
        r.ir = (phase == TX_HDR_MARK || phase == TX_BIT_MARK) ? carrier : 1'b0;
      end else begin
        case (phase)
          TX_HDR_MARK: begin
            r.ir = carrier;
            if (mark_step(hdr_cycles)) phase = TX_HDR_SPACE;
          end
          TX_HDR_SPACE: begin
            if (space_step(hdr_space)) begin
              phase   = TX_BIT_MARK;
              carrier = 1'b1;
            end
          end
          TX_BIT_MARK: begin
            r.ir = carrier;
            if (mark_step(bit_cycles)) phase = TX_BIT_SPACE;
          end
          TX_BIT_SPACE: begin
            if (space_step(shift_word[0] ? one_space : zero_space)) begin
              shift_word = shift_word >> 1;
              if (bits_left != 0) bits_left = bits_left - 1'b1;
              if (bits_left == 0) begin
                phase  = TX_IDLE;
                r.done = 1'b1;
              end else begin
                phase   = TX_BIT_MARK;
                carrier = 1'b1;
              end
            end
          end
          default: phase = TX_IDLE;
        endcase
      end
      r.busy = (phase != TX_IDLE);
      expected_q.push_back(r);
    endfunction

    function void check_result(pin_result_t got);
      pin_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result ir %b busy %b done %b ignored %b",
                   $realtime, got.ir, got.busy, got.done, got.ignored);
        return;
      end
      want = expected_q.pop_front();
      if (got.ir !== want.ir || got.busy !== want.busy || got.done !== want.done ||
          got.ignored !== want.ignored) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: exp/act ir %b/%b busy %b/%b done %b/%b ignored %b/%b",
                   $realtime, want.ir, got.ir, want.busy, got.busy, want.done, got.done,
                   want.ignored, got.ignored);
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic                           kind = irpd_pkg::KIND_TICK;
  logic [irpd_pkg::FRAME_W-1:0]   frame_word = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic                           ir_out;
  logic                           busy_res;
  logic                           frame_done;
  logic                           start_ignored;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [irpd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [irpd_pkg::CFG_DAT_W-1:0] cfg_data = '0;

  IrFrameScoreboard sb;
  bit calm      = 1'b0;
  bit hold_long = 1'b0;
  int idle_pct  = 0;
  int stall_pct = 0;

  ir_pulse_distance_transmitter_unit uut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result({ir_out, busy_res, frame_done, start_ignored});
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
        hold_long = 1'b0;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 18)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_item(logic k, logic [irpd_pkg::FRAME_W-1:0] word);
    in_valid   <= 1'b1;
    kind       <= k;
    frame_word <= word;
    do @(posedge clk); while (!in_ready);
    sb.note_input(k, word);
  endtask

  task automatic pause_input(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [irpd_pkg::CFG_IDX_W-1:0] idx,
                           logic [irpd_pkg::CFG_DAT_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic set_timing(logic [irpd_pkg::CFG_DAT_W-1:0] half,
                            logic [irpd_pkg::CFG_DAT_W-1:0] hm,
                            logic [irpd_pkg::CFG_DAT_W-1:0] hs,
                            logic [irpd_pkg::CFG_DAT_W-1:0] bm,
                            logic [irpd_pkg::CFG_DAT_W-1:0] zs,
                            logic [irpd_pkg::CFG_DAT_W-1:0] os);
    write_reg(irpd_pkg::CFG_CARRIER_HALF, half);
    write_reg(irpd_pkg::CFG_HDR_MARK, hm);
    write_reg(irpd_pkg::CFG_HDR_SPACE, hs);
    write_reg(irpd_pkg::CFG_BIT_MARK, bm);
    write_reg(irpd_pkg::CFG_ZERO_SPACE, zs);
    write_reg(irpd_pkg::CFG_ONE_SPACE, os);
    cfg_valid <= 1'b0;
  endtask

  // keep frames short; junk in the unused upper bits
  task automatic random_timing();
    set_timing({8'($urandom()), 8'($urandom_range(0, 2))},
               {6'($urandom()), 10'($urandom_range(0, 3))},
               16'($urandom_range(0, 6)),
               {6'($urandom()), 10'($urandom_range(0, 2))},
               16'($urandom_range(0, 4)),
               16'($urandom_range(0, 6)));
  endtask

  task automatic run_frames(int n);
    logic k;
    for (int i = 0; i < n; i++) begin
      if (!calm && $urandom_range(0, 99) < idle_pct) pause_input($urandom_range(1, 19));
      if (sb.phase == TX_IDLE)
        k = ($urandom_range(0, 3) == 0) ? irpd_pkg::KIND_START : irpd_pkg::KIND_TICK;
      else
        k = ($urandom_range(0, 49) == 0) ? irpd_pkg::KIND_START : irpd_pkg::KIND_TICK;
      send_item(k, $urandom());
    end
    drain();
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(irpd_pkg::KIND_TICK, '1);
    send_item(irpd_pkg::KIND_START, '1);
    send_item(irpd_pkg::KIND_START, '0);
    repeat (5) send_item(irpd_pkg::KIND_TICK, '0);
    drain();

    write_reg(CFG_SPARE_A, '1);
    write_reg(CFG_SPARE_B, '1);
    set_timing('0, '0, '0, '0, '0, '0);
    idle_pct  = 25;
    stall_pct = 10;
    hold_long = 1'b1;
    run_frames(220);

    set_timing(16'd1, 16'd2, 16'd3, 16'd1, 16'd1, 16'd3);
    idle_pct  = 0;
    stall_pct = 0;
    run_frames(300);

    set_timing('1, '1, '1, '1, '1, '1);
    idle_pct  = 40;
    stall_pct = 30;
    run_frames(40);

    repeat (4) begin
      random_timing();
      idle_pct  = $urandom_range(0, 3) * 15;
      stall_pct = $urandom_range(0, 3) * 10;
      run_frames(220);
    end

    calm = 1'b1;
    random_timing();
    run_frames(200);

    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0)
      $display("tb_ir_pulse_distance_transmitter_unit OK");
    else
      $display("tb_ir_pulse_distance_transmitter_unit NOT OK");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_ir_pulse_distance_transmitter_unit NOT OK");
    $finish;
  end

endmodule
